// ----- rtl/wicq_pkg.sv -----
// wicq_pkg: shared types and constants for the weighted in-order commit queue
// no dependencies; imported by the interfaces and every module of the block but wicq_ram
`default_nettype none

package wicq_pkg;

  // field widths fixed by the item format
  localparam int unsigned ID_W     = 16;
  localparam int unsigned WGT_W    = 5;
  localparam int unsigned UOP_W    = 8;
  localparam int unsigned CW_W     = 5;
  localparam int unsigned LIM_W    = 7;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  // weight used so far plus one head weight: 16 + 31 fits in 6 bits
  localparam int unsigned SUM_W    = 6;

  // defaults for the top-level parameters
  localparam int unsigned DEF_QUEUE_DEPTH  = 64;
  localparam int unsigned DEF_MAX_WIDTH    = 16;
  localparam int unsigned DEF_COUNTER_BITS = 48;

  // reset values of the configuration registers
  localparam logic [CW_W-1:0]  CW_RESET  = 5'd4;
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMMIT_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 1'd1;

  // item operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  inst_id;
    logic [WGT_W-1:0] weight;
    logic [UOP_W-1:0] micro_ops;
    logic             is_float;
    logic             is_call;
  } in_item_t;

  typedef struct packed {
    logic               committed_valid;
    logic [ID_W-1:0]    committed_id;
    logic               last;
    logic               stall_res;
    logic               overflow;
    logic [TOTAL_W-1:0] total_insts;
    logic [TOTAL_W-1:0] total_ops;
    logic [TOTAL_W-1:0] total_int;
    logic [TOTAL_W-1:0] total_float;
    logic [TOTAL_W-1:0] total_call;
    logic [TOTAL_W-1:0] total_blocked;
  } out_item_t;

  // one queue entry as held in the store
  typedef struct packed {
    logic             is_call;
    logic             is_float;
    logic [UOP_W-1:0] micro_ops;
    logic [WGT_W-1:0] weight;
    logic [ID_W-1:0]  inst_id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // classified command handed from the front to the back
  typedef struct packed {
    logic   is_tick;
    entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/wicq_ifs.sv -----
// wicq_ifs: valid/ready channel interfaces for input and result items
// depends on wicq_pkg for the payload types
`default_nettype none

interface wicq_in_if;
  import wicq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wicq_out_if;
  import wicq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/weighted_inorder_commit_queue.sv -----
// Weighted in-order commit queue. An arrive item appends an instruction to a
// ring of QUEUE_DEPTH entries held in one RAM and yields one result, with
// overflow set when the ring was full. A tick item retires from the head in
// order while the weight used stays within commit_width (saturated to
// MAX_WIDTH) and yields one result per retired instruction, or a single empty
// result; every result of a tick carries the stall flag and totals as they
// stand after the whole tick. A front part takes items into a two-entry
// command queue; the back part executes one command at a time and leaves its
// results in an output register. An arrive is accepted and then emits its
// result; a tick passes through accept, a first RAM read, one evaluation per
// entry retired plus the one that stops, and a closing step, then emits one
// result per retired instruction or a single empty result; result stalls hold
// the emit step. The RAM is not cleared after reset and needs no clearing pass.
// Depends on wicq_pkg, wicq_ifs, wicq_front, wicq_back, wicq_ram.
`default_nettype none

module weighted_inorder_commit_queue #(
  parameter int unsigned QUEUE_DEPTH  = wicq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_WIDTH    = wicq_pkg::DEF_MAX_WIDTH,
  parameter int unsigned COUNTER_BITS = wicq_pkg::DEF_COUNTER_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  wicq_in_if.sink                              in_ch,
  wicq_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [wicq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wicq_pkg::CFG_W-1:0]      cfg_data
);
  import wicq_pkg::*;

  logic [CW_W-1:0]  commit_width_r;
  logic [LIM_W-1:0] queue_limit_r;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_width_r <= CW_RESET;
      queue_limit_r  <= LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMMIT_WIDTH: commit_width_r <= cfg_data[CW_W-1:0];
        REG_QUEUE_LIMIT:  queue_limit_r  <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wicq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  wicq_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_WIDTH    (MAX_WIDTH),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .commit_width (commit_width_r),
    .queue_limit  (queue_limit_r),
    .out_ch       (out_ch)
  );

`ifndef SYNTH
  // an empty result always closes its item
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.committed_valid) |-> out_ch.data.last)
    else $error("empty result without last");

  // an empty result reports a zero id
  a_empty_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.committed_valid) |-> (out_ch.data.committed_id == '0))
    else $error("empty result with nonzero id");

  // a dropped arrive is never reported as a commit
  a_overflow_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.overflow) |->
      (!out_ch.data.committed_valid && out_ch.data.last))
    else $error("overflow on a commit result");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/wicq_ram.sv -----
// wicq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module wicq_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/wicq_front.sv -----
// wicq_front: accepts input items, classifies them into arrive/tick commands
// and holds them in a two-entry command queue; depends on wicq_pkg, wicq_ifs
`default_nettype none

module wicq_front (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wicq_in_if.sink    in_ch,
  output wicq_pkg::cmd_t cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_ready
);
  import wicq_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.is_tick          = (in_ch.data.op == OP_TICK);
    cmd_in.entry.inst_id    = in_ch.data.inst_id;
    cmd_in.entry.weight     = in_ch.data.weight;
    cmd_in.entry.micro_ops  = in_ch.data.micro_ops;
    cmd_in.entry.is_float   = in_ch.data.is_float;
    cmd_in.entry.is_call    = in_ch.data.is_call;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = slot_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_valid && cmd_ready;

  // command queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wicq_back.sv -----
// wicq_back: commit engine; owns the entry store, ring pointers and totals,
// retires from the head and emits result items; depends on wicq_pkg, wicq_ifs,
// wicq_ram
`default_nettype none

module wicq_back #(
  parameter int unsigned QUEUE_DEPTH  = wicq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_WIDTH    = wicq_pkg::DEF_MAX_WIDTH,
  parameter int unsigned COUNTER_BITS = wicq_pkg::DEF_COUNTER_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire wicq_pkg::cmd_t               cmd,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire logic [wicq_pkg::CW_W-1:0]    commit_width,
  input  wire logic [wicq_pkg::LIM_W-1:0]   queue_limit,
  wicq_out_if.source                        out_ch
);
  import wicq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > LIM_W) ? OCC_W : LIM_W;
  localparam int unsigned NUM_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CNT_W = COUNTER_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [OCC_W-1:0]  occ_r;
  logic [SUM_W-1:0]  used_r;
  logic [NUM_W-1:0]  n_r;
  logic [NUM_W-1:0]  k_r;
  logic              ovf_r;
  logic [ID_W-1:0]   ids_r [MAX_WIDTH];
  logic [CNT_W-1:0]  insts_r;
  logic [CNT_W-1:0]  ops_r;
  logic [CNT_W-1:0]  int_r;
  logic [CNT_W-1:0]  float_r;
  logic [CNT_W-1:0]  call_r;
  logic [CNT_W-1:0]  blocked_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  tail_adv;
  logic [PTR_W-1:0]  raddr;
  entry_t            head_entry;
  logic [ENTRY_W-1:0] rdata;
  logic              full;
  logic              stall;
  logic [WGT_W-1:0]  width_eff;
  logic [SUM_W-1:0]  used_nxt;
  logic              retire;
  logic              take;
  logic              mem_we;
  logic              emit_go;
  logic              emit_last;

  // ring pointer advance with wrap at the queue depth
  assign head_adv = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_adv = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign full  = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign stall = (CMP_W'(occ_r) >= CMP_W'(queue_limit));

  // commit width saturated to the widest supported
  assign width_eff = (commit_width > CW_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : commit_width;

  assign cmd_ready = (state_r == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign mem_we    = take && !cmd.is_tick && !full;

  // while retiring, prefetch the entry after the head
  assign raddr      = (state_r == S_EV) ? head_adv : head_r;
  assign head_entry = entry_t'(rdata);

  wicq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (cmd.entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // retire decision for the current head
  always_comb begin
    used_nxt = used_r + SUM_W'(head_entry.weight);
    retire   = (state_r == S_EV) && (occ_r != '0)
               && (used_r < SUM_W'(width_eff))
               && (n_r < NUM_W'(MAX_WIDTH))
               && (used_nxt <= SUM_W'(width_eff));
  end

  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last = (n_r == '0) || (k_r + 1'b1 == n_r);

  // sequencer, store bookkeeping, totals and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      used_r      <= '0;
      n_r         <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      insts_r     <= '0;
      ops_r       <= '0;
      int_r       <= '0;
      float_r     <= '0;
      call_r      <= '0;
      blocked_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take) begin
            used_r <= '0;
            n_r    <= '0;
            k_r    <= '0;
            if (cmd.is_tick) begin
              ovf_r   <= 1'b0;
              state_r <= S_RD;
            end else begin
              ovf_r <= full;
              if (!full) begin
                tail_r <= tail_adv;
                occ_r  <= occ_r + 1'b1;
              end
              state_r <= S_EMIT;
            end
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          if (retire) begin
            head_r   <= head_adv;
            occ_r    <= occ_r - 1'b1;
            used_r   <= used_nxt;
            ids_r[n_r[IDX_W-1:0]] <= head_entry.inst_id;
            n_r      <= n_r + 1'b1;
            insts_r  <= insts_r + 1'b1;
            ops_r    <= ops_r + CNT_W'(head_entry.micro_ops);
            if (head_entry.is_float) begin
              float_r <= float_r + 1'b1;
            end else begin
              int_r <= int_r + 1'b1;
            end
            if (head_entry.is_call) begin
              call_r <= call_r + 1'b1;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (stall) begin
            blocked_r <= blocked_r + 1'b1;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r                <= 1'b1;
            out_data_r.committed_valid <= (n_r != '0);
            out_data_r.committed_id    <= (n_r != '0) ? ids_r[k_r[IDX_W-1:0]] : '0;
            out_data_r.last            <= emit_last;
            out_data_r.stall_res       <= stall;
            out_data_r.overflow        <= ovf_r;
            out_data_r.total_insts     <= TOTAL_W'(insts_r);
            out_data_r.total_ops       <= TOTAL_W'(ops_r);
            out_data_r.total_int       <= TOTAL_W'(int_r);
            out_data_r.total_float     <= TOTAL_W'(float_r);
            out_data_r.total_call      <= TOTAL_W'(call_r);
            out_data_r.total_blocked   <= TOTAL_W'(blocked_r);
            k_r <= k_r + 1'b1;
            if (emit_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for weighted_inorder_commit_queue with a retire scoreboard
// depends on wicq_pkg, wicq_ifs and the rtl of the block; needs no other file
`default_nettype none

module tb;
  import wicq_pkg::*;

  // tracks the retire queue and totals, and holds the result items still owed
  class retire_scoreboard;
    entry_t             ring[$];
    logic [CW_W-1:0]    width_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic [TOTAL_W-1:0] sum_insts, sum_ops, sum_int, sum_float, sum_call, sum_blocked;
    out_item_t          owed[$];
    int unsigned        errors, checked, arrives, ticks, commits, drops, stalls, max_burst;

    function new();
      width_reg   = CW_RESET;
      limit_reg   = LIM_RESET;
      sum_insts   = '0;
      sum_ops     = '0;
      sum_int     = '0;
      sum_float   = '0;
      sum_call    = '0;
      sum_blocked = '0;
      errors      = 0;
      checked     = 0;
      arrives     = 0;
      ticks       = 0;
      commits     = 0;
      drops       = 0;
      stalls      = 0;
      max_burst   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_COMMIT_WIDTH) width_reg = val[CW_W-1:0];
      else if (idx == REG_QUEUE_LIMIT) limit_reg = val[LIM_W-1:0];
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    // one result with the stall flag and totals as they stand now
    function out_item_t snapshot(logic vld, logic [ID_W-1:0] id, logic lst, logic ovf);
      out_item_t r;
      r.committed_valid = vld;
      r.committed_id    = id;
      r.last            = lst;
      r.stall_res       = (ring.size() >= int'(limit_reg));
      r.overflow        = ovf;
      r.total_insts     = sum_insts;
      r.total_ops       = sum_ops;
      r.total_int       = sum_int;
      r.total_float     = sum_float;
      r.total_call      = sum_call;
      r.total_blocked   = sum_blocked;
      if (r.stall_res) stalls++;
      return r;
    endfunction

    // work out the results of one accepted item
    function void note_item(in_item_t it);
      entry_t          e;
      logic [ID_W-1:0] ids[$];
      int unsigned     cap;
      int unsigned     used;
      logic            drop;
      if (it.op == OP_ARRIVE) begin
        arrives++;
        drop = (ring.size() >= int'(DEF_QUEUE_DEPTH));
        if (!drop) begin
          e.inst_id   = it.inst_id;
          e.weight    = it.weight;
          e.micro_ops = it.micro_ops;
          e.is_float  = it.is_float;
          e.is_call   = it.is_call;
          ring = {ring, e};
        end else begin
          drops++;
        end
        owed = {owed, snapshot(1'b0, '0, 1'b1, drop)};
      end else begin
        ticks++;
        cap  = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
        used = 0;
        // retire from the head while the weight budget allows
        while (ring.size() > 0 && used < cap && ids.size() < int'(DEF_MAX_WIDTH)) begin
          e = ring[0];
          if (used + e.weight > cap) break;
          used += e.weight;
          ring.delete(0);
          ids = {ids, e.inst_id};
          sum_insts += TOTAL_W'(1);
          sum_ops   += TOTAL_W'(e.micro_ops);
          if (e.is_float) sum_float += TOTAL_W'(1);
          else sum_int += TOTAL_W'(1);
          if (e.is_call) sum_call += TOTAL_W'(1);
        end
        if (ring.size() >= int'(limit_reg)) sum_blocked += TOTAL_W'(1);
        commits += ids.size();
        if (ids.size() > max_burst) max_burst = ids.size();
        if (ids.size() == 0) owed = {owed, snapshot(1'b0, '0, 1'b1, 1'b0)};
        for (int k = 0; k < ids.size(); k++)
          owed = {owed, snapshot(1'b1, ids[k], k == ids.size() - 1, 1'b0)};
      end
    endfunction

    function void check_field(string fld, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", fld, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("result item with nothing owed, id %0h", got.committed_id);
        errors++;
        return;
      end
      want = owed[0];
      owed.delete(0);
      checked++;
      check_field("committed_valid", 64'(want.committed_valid), 64'(got.committed_valid));
      check_field("committed_id", 64'(want.committed_id), 64'(got.committed_id));
      check_field("last", 64'(want.last), 64'(got.last));
      check_field("stall_res", 64'(want.stall_res), 64'(got.stall_res));
      check_field("overflow", 64'(want.overflow), 64'(got.overflow));
      check_field("total_insts", 64'(want.total_insts), 64'(got.total_insts));
      check_field("total_ops", 64'(want.total_ops), 64'(got.total_ops));
      check_field("total_int", 64'(want.total_int), 64'(got.total_int));
      check_field("total_float", 64'(want.total_float), 64'(got.total_float));
      check_field("total_call", 64'(want.total_call), 64'(got.total_call));
      check_field("total_blocked", 64'(want.total_blocked), 64'(got.total_blocked));
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 9;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          src_idle_pct;
  int unsigned          sink_idle_pct;
  int unsigned          cycles;

  // per phase: commit width, queue limit, item count, arrive share, zero-weight share
  int unsigned ph_width [NUM_PHASES] = '{4, 1, 16, 0, 8, 16, 31, 2, 16};
  int unsigned ph_limit [NUM_PHASES] = '{32, 64, 8, 64, 1, 127, 0, 40, 16};
  int unsigned ph_len   [NUM_PHASES] = '{40, 40, 40, 90, 45, 45, 40, 40, 40};
  int unsigned ph_arrive[NUM_PHASES] = '{60, 55, 55, 95, 30, 60, 55, 55, 50};
  int unsigned ph_zero  [NUM_PHASES] = '{10, 20, 10, 10, 10, 60, 30, 15, 10};

  retire_scoreboard sb = new();

  wicq_in_if  in_ch ();
  wicq_out_if out_ch ();

  weighted_inorder_commit_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check accepted items, stall at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic in_item_t make_arrive(logic [ID_W-1:0] id, logic [WGT_W-1:0] w,
                                           logic [UOP_W-1:0] uops, logic flt, logic call);
    in_item_t it;
    it.op        = OP_ARRIVE;
    it.inst_id   = id;
    it.weight    = w;
    it.micro_ops = uops;
    it.is_float  = flt;
    it.is_call   = call;
    return it;
  endfunction

  // random item; weights mostly fit the width, some are heavy or zero
  function automatic in_item_t rand_item(int unsigned arrive_pct, int unsigned wcap,
                                         int unsigned zero_pct);
    in_item_t    it;
    int unsigned roll;
    int unsigned top;
    it.op        = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
    it.inst_id   = ID_W'($urandom);
    it.micro_ops = UOP_W'($urandom);
    it.is_float  = 1'($urandom_range(1));
    it.is_call   = 1'($urandom_range(1));
    top  = (wcap == 0) ? 1 : ((wcap > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wcap);
    roll = $urandom_range(99);
    if (roll < zero_pct) it.weight = '0;
    else if (roll < zero_pct + 8) it.weight = WGT_W'($urandom_range(DEF_MAX_WIDTH, 1));
    else it.weight = WGT_W'($urandom_range(top, 1));
    return it;
  endfunction

  // offer one item, holding valid across back-to-back items
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  // stop sending until every owed result has come back
  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // both registers, written while the block is idle
  task automatic write_regs(input int unsigned w, input int unsigned lim);
    drain_pause();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COMMIT_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    sb.set_reg(REG_COMMIT_WIDTH, CFG_W'(w));
    cfg_index <= REG_QUEUE_LIMIT;
    cfg_data  <= CFG_W'(lim);
    @(posedge clk);
    sb.set_reg(REG_QUEUE_LIMIT, CFG_W'(lim));
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    src_idle_pct  = 35;
    sink_idle_pct = 53;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty tick, field extremes, a head too heavy for width 4
    send_item(rand_item(0, 16, 0));
    send_item(make_arrive(16'h0000, 5'd0, 8'h00, 1'b0, 1'b0));
    send_item(make_arrive(16'hFFFF, 5'd4, 8'hFF, 1'b1, 1'b1));
    send_item(make_arrive(16'h1234, 5'd1, 8'h80, 1'b0, 1'b1));
    send_item(make_arrive(16'hA5A5, 5'd16, 8'h01, 1'b1, 1'b0));
    send_item(rand_item(0, 16, 0));
    send_item(rand_item(0, 16, 0));
    send_item(rand_item(0, 16, 0));

    // full width frees the heavy head; zero limit keeps stall up
    write_regs(16, 0);
    send_item(rand_item(0, 16, 0));
    send_item(make_arrive(16'h5A5A, 5'd0, 8'h7F, 1'b1, 1'b1));
    send_item(rand_item(0, 16, 0));

    // zero width retires nothing, not even weightless entries
    write_regs(0, 1);
    send_item(make_arrive(16'h0F0F, 5'd2, 8'h3C, 1'b0, 1'b0));
    send_item(make_arrive(16'hF0F0, 5'd0, 8'hC3, 1'b1, 1'b0));
    send_item(rand_item(0, 16, 0));

    // width above the maximum saturates, widest limit
    write_regs(31, 127);
    send_item(make_arrive(16'h8001, 5'd16, 8'h55, 1'b0, 1'b1));
    send_item(make_arrive(16'h7FFE, 5'd0, 8'hAA, 1'b1, 1'b1));
    send_item(rand_item(0, 16, 0));
    send_item(rand_item(0, 16, 0));
    send_item(rand_item(0, 16, 0));
    send_item(rand_item(0, 16, 0));

    // random phases; idling swaps sides after each third, then stops
    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle_pct  = (p < 3) ? 35 : ((p < 6) ? 53 : 0);
      sink_idle_pct = (p < 3) ? 53 : ((p < 6) ? 35 : 0);
      write_regs(ph_width[p], ph_limit[p]);
      for (int i = 0; i < ph_len[p]; i++) begin
        if (p % 3 == 1 && i == ph_len[p] / 2) drain_pause();
        send_item(rand_item(ph_arrive[p], ph_width[p], ph_zero[p]));
      end
    end

    // heads heavier than any width block for good, so they come last
    send_item(make_arrive(16'hBEEF, 5'd31, 8'hFE, 1'b1, 1'b0));
    send_item(make_arrive(16'hCAFE, 5'd17, 8'h01, 1'b0, 1'b1));
    send_item(make_arrive(16'h4321, 5'd1, 8'h10, 1'b0, 1'b0));
    for (int i = 0; i < 4; i++) send_item(rand_item(0, 16, 0));

    drain_pause();
    repeat (40) @(posedge clk);
    $display("covered %0d arrive and %0d tick items: %0d commits, %0d dropped arrivals",
             sb.arrives, sb.ticks, sb.commits, sb.drops);
    $display("checked %0d results, %0d with stall, longest commit burst %0d",
             sb.checked, sb.stalls, sb.max_burst);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire
